// ----- src/brib_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brib_pkg;

    // Fixed field widths
    localparam int CFG_W  = 24;   // widest configuration register
    localparam int IDX_W  = 3;    // register index
    localparam int DT_W   = 16;   // time step, unsigned Q8.8
    localparam int OUT_W  = 24;   // result position and velocity fields

    // Rounding of the Q20.20 displacement down to Q12.12
    localparam int FRAC_SHIFT = 8;
    localparam int ROUND_BIAS = 128;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_TABLE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TABLE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_X      = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_Y      = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_VX     = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_VY     = 3'd5;

    // Reset values of the table size registers
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 24'd409600;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 24'd204800;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture time step and start-outside flag
        logic mul;     // form velocity times time step
        logic add;     // form the unfolded new position
        logic fold;    // run one fold round on both axes
        logic write;   // clamp, commit state and load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_outside;
        logic settled;         // inside, or the fold budget is spent
    } t_status;

endpackage

`default_nettype wire

// ----- src/ball_reflect_in_box.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_time_step (Q8.8)
// result    out        o_out_valid / i_out_stall    o_pos_x, o_pos_y, o_vel_x, o_vel_y,
//                                                   o_start_outside, o_fold_limit_hit
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// One item at a time: accept, multiply, add, then the fold rounds plus one
// settling check, then the result write. There are 0 to MAX_FOLDS fold rounds
// per item. A start point outside the table goes from the multiply straight to
// the result write.
// Reset (synchronous, active low) restores the table size registers and zeroes
// the start position and ball state; the result register holds one finished
// item, so a stalled result stalls the block only at the next write.

module ball_reflect_in_box #(
    parameter int POS_WIDTH = 24,
    parameter int MAX_FOLDS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [brib_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [brib_pkg::CFG_W-1:0]   i_cfg_data,
    // input items
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [brib_pkg::DT_W-1:0]    i_time_step,
    // result items
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [brib_pkg::OUT_W-1:0]        o_pos_x,
    output logic [brib_pkg::OUT_W-1:0]        o_pos_y,
    output logic signed [brib_pkg::OUT_W-1:0] o_vel_x,
    output logic signed [brib_pkg::OUT_W-1:0] o_vel_y,
    output logic                              o_start_outside,
    output logic                              o_fold_limit_hit
);
    import brib_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequence the item: accept, multiply, add, fold rounds, write
    brib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Hold configuration, ball state and the fold arithmetic
    brib_datapath #(
        .POS_WIDTH (POS_WIDTH),
        .MAX_FOLDS (MAX_FOLDS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_time_step      (i_time_step),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_vel_x          (o_vel_x),
        .o_vel_y          (o_vel_y),
        .o_start_outside  (o_start_outside),
        .o_fold_limit_hit (o_fold_limit_hit)
    );

endmodule

`default_nettype wire

// ----- src/brib_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brib_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire brib_pkg::t_status i_status,
    output brib_pkg::t_cmd        o_cmd
);
    import brib_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_ADD   = 5'b00100,
        S_FOLD  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.start_outside ? S_WRITE : S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_FOLD;
            end
            S_FOLD: begin
                if (i_status.settled) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.fold = 1'b1;
                end
            end
            S_WRITE: begin
                if (w_slot_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.write) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A result is never loaded over one that is still waiting
    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // An accepted item starts the multiply on the next cycle
    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL))
        else $error("accepted item did not start");

    // Output valid only rises after a write command
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.write))
        else $error("result valid without write");

    // No fold round once the ball has settled or the budget is spent
    a_fold_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fold |-> !i_status.settled)
        else $error("fold issued after settling");

endmodule

`default_nettype wire

// ----- src/brib_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brib_datapath #(
    parameter int POS_WIDTH = 24,
    parameter int MAX_FOLDS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [brib_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [brib_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic [brib_pkg::DT_W-1:0]    i_time_step,
    input  wire brib_pkg::t_cmd               i_cmd,
    output brib_pkg::t_status                 o_status,
    output logic [brib_pkg::OUT_W-1:0]        o_pos_x,
    output logic [brib_pkg::OUT_W-1:0]        o_pos_y,
    output logic signed [brib_pkg::OUT_W-1:0] o_vel_x,
    output logic signed [brib_pkg::OUT_W-1:0] o_vel_y,
    output logic                              o_start_outside,
    output logic                              o_fold_limit_hit
);
    import brib_pkg::*;

    localparam int PW  = POS_WIDTH;
    localparam int PRW = PW + DT_W + 1;        // signed v times unsigned dt
    localparam int XW  = PW + 19;              // position during folding
    localparam int CW  = $clog2(MAX_FOLDS + 1);

    typedef struct packed {
        logic signed [XW-1:0] p;
        logic signed [PW-1:0] v;
    } t_axis;

    logic [CFG_W-1:0]     r_width, r_height, r_start_x, r_start_y;
    logic [PW-1:0]        r_ball_x, r_ball_y;
    logic signed [PW-1:0] r_ball_vx, r_ball_vy;
    logic [DT_W-1:0]      r_dt;
    logic                 r_outside;
    logic signed [PRW-1:0] r_prod_x, r_prod_y;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [PW-1:0] r_vx, r_vy;
    logic [CW-1:0]        r_cnt;

    logic signed [XW-1:0] w_lim_x, w_lim_y, w_cx, w_cy;
    logic signed [XW-1:0] w_cfg_pos, w_cfg_vel;
    logic                 w_inside;
    t_axis                w_fx, w_fy;

    function automatic logic signed [PW-1:0] f_neg_sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] vmin;
        vmin = {1'b1, {(PW-1){1'b0}}};
        return (v == vmin) ? {1'b0, {(PW-1){1'b1}}} : -v;
    endfunction

    // Round half up: add the bias, then arithmetic shift
    function automatic logic signed [XW-1:0] f_disp(input logic signed [PRW-1:0] p);
        logic signed [XW-1:0] w;
        w = {{(XW-PRW){p[PRW-1]}}, p} + XW'(ROUND_BIAS);
        return w >>> FRAC_SHIFT;
    endfunction

    function automatic logic f_in_axis(input logic signed [XW-1:0] p,
                                       input logic signed [XW-1:0] lim);
        return !p[XW-1] && (p < lim);
    endfunction

    // Fold back across the low wall, then the high wall
    function automatic t_axis f_fold(input logic signed [XW-1:0] p,
                                     input logic signed [PW-1:0] v,
                                     input logic signed [XW-1:0] lim);
        t_axis a;
        a.p = p;
        a.v = v;
        if (p[XW-1]) begin
            a.p = -p;
            a.v = f_neg_sat(v);
        end
        if (a.p >= lim) begin
            a.p = (a.p == lim) ? (lim - XW'(1)) : ((lim <<< 1) - a.p);
            a.v = f_neg_sat(a.v);
        end
        return a;
    endfunction

    function automatic logic signed [XW-1:0] f_clamp(input logic signed [XW-1:0] p,
                                                     input logic signed [XW-1:0] lim);
        if (p[XW-1]) begin
            return '0;
        end else if (p >= lim) begin
            return lim - XW'(1);
        end
        return p;
    endfunction

    assign w_lim_x   = {{(XW-CFG_W){1'b0}}, r_width};
    assign w_lim_y   = {{(XW-CFG_W){1'b0}}, r_height};
    assign w_inside  = f_in_axis(r_x, w_lim_x) && f_in_axis(r_y, w_lim_y);
    assign w_fx      = f_fold(r_x, r_vx, w_lim_x);
    assign w_fy      = f_fold(r_y, r_vy, w_lim_y);
    assign w_cx      = f_clamp(r_x, w_lim_x);
    assign w_cy      = f_clamp(r_y, w_lim_y);
    assign w_cfg_pos = {{(XW-CFG_W){1'b0}}, i_cfg_data};
    assign w_cfg_vel = {{(XW-CFG_W){i_cfg_data[CFG_W-1]}}, i_cfg_data};

    assign o_status.start_outside = r_outside;
    assign o_status.settled       = w_inside || (r_cnt == CW'(MAX_FOLDS));

    // Configuration registers and ball state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RESET_WIDTH;
            r_height  <= RESET_HEIGHT;
            r_start_x <= '0;
            r_start_y <= '0;
            r_ball_x  <= '0;
            r_ball_y  <= '0;
            r_ball_vx <= '0;
            r_ball_vy <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TABLE_WIDTH:  r_width  <= i_cfg_data;
                    REG_TABLE_HEIGHT: r_height <= i_cfg_data;
                    REG_START_X: begin
                        r_start_x <= i_cfg_data;
                        r_ball_x  <= w_cfg_pos[PW-1:0];
                    end
                    REG_START_Y: begin
                        r_start_y <= i_cfg_data;
                        r_ball_y  <= w_cfg_pos[PW-1:0];
                    end
                    REG_START_VX: r_ball_vx <= w_cfg_vel[PW-1:0];
                    REG_START_VY: r_ball_vy <= w_cfg_vel[PW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.write && !r_outside) begin
                r_ball_x  <= w_cx[PW-1:0];
                r_ball_y  <= w_cy[PW-1:0];
                r_ball_vx <= r_vx;
                r_ball_vy <= r_vy;
            end
        end
    end

    // Working registers and the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt      <= i_time_step;
            r_outside <= !((r_start_x < r_width) && (r_start_y < r_height));
        end
        if (i_cmd.mul) begin
            r_prod_x <= r_ball_vx * $signed({1'b0, r_dt});
            r_prod_y <= r_ball_vy * $signed({1'b0, r_dt});
        end
        if (i_cmd.add) begin
            r_x   <= $signed({{(XW-PW){1'b0}}, r_ball_x}) + f_disp(r_prod_x);
            r_y   <= $signed({{(XW-PW){1'b0}}, r_ball_y}) + f_disp(r_prod_y);
            r_vx  <= r_ball_vx;
            r_vy  <= r_ball_vy;
            r_cnt <= '0;
        end
        if (i_cmd.fold) begin
            r_x   <= w_fx.p;
            r_y   <= w_fy.p;
            r_vx  <= w_fx.v;
            r_vy  <= w_fy.v;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.write) begin
            if (r_outside) begin
                o_pos_x          <= OUT_W'(r_ball_x);
                o_pos_y          <= OUT_W'(r_ball_y);
                o_vel_x          <= OUT_W'(r_ball_vx);
                o_vel_y          <= OUT_W'(r_ball_vy);
                o_start_outside  <= 1'b1;
                o_fold_limit_hit <= 1'b0;
            end else begin
                o_pos_x          <= w_cx[OUT_W-1:0];
                o_pos_y          <= w_cy[OUT_W-1:0];
                o_vel_x          <= OUT_W'(r_vx);
                o_vel_y          <= OUT_W'(r_vy);
                o_start_outside  <= 1'b0;
                o_fold_limit_hit <= !w_inside;
            end
        end
    end

endmodule

`default_nettype wire
